// ----- hdl/signed_integer_alu64_macros.svh -----
// Assertion macros for the signed integer ALU.
`ifndef SIGNED_INTEGER_ALU64_MACROS_SVH
`define SIGNED_INTEGER_ALU64_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define SIA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SIA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SIA_ASSERT(lbl, prop, msg)
`define SIA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/sia_pkg.sv -----
package sia_pkg;

    typedef enum logic [4:0] {
        OP_MUL    = 5'd0,
        OP_DIV    = 5'd1,
        OP_MOD    = 5'd2,
        OP_ADD    = 5'd3,
        OP_SUB    = 5'd4,
        OP_SHL    = 5'd5,
        OP_SAR    = 5'd6,
        OP_SHR    = 5'd7,
        OP_AND    = 5'd8,
        OP_XOR    = 5'd9,
        OP_OR     = 5'd10,
        OP_LT     = 5'd11,
        OP_GT     = 5'd12,
        OP_LE     = 5'd13,
        OP_GE     = 5'd14,
        OP_EQ     = 5'd15,
        OP_NE     = 5'd16,
        OP_LAND   = 5'd17,
        OP_LOR    = 5'd18,
        OP_BITNOT = 5'd19,
        OP_LNOT   = 5'd20,
        OP_NEG    = 5'd21,
        OP_POS    = 5'd22
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_SHIFT = 2'd2
    } t_status;

    // What the cell chain does with a transaction.
    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2,
        K_MOD  = 2'd3
    } t_kind;

    typedef struct packed {
        logic    vld;
        t_kind   kind;
        logic    neg;   // negate the final quotient / remainder
        t_status st;
    } t_ctl;

endpackage

// ----- hdl/sia_cell.sv -----
// One step of shift-add multiply or restoring divide; other transactions pass through.
// mul: r = accumulator, d = multiplicand, x = multiplier
// div: r = partial remainder, d = divisor, x = dividend -> quotient
module sia_cell #(
    parameter int W = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  sia_pkg::t_ctl i_ctl,
    input  logic [W-1:0]  i_r,
    input  logic [W-1:0]  i_d,
    input  logic [W-1:0]  i_x,
    output sia_pkg::t_ctl o_ctl,
    output logic [W-1:0]  o_r,
    output logic [W-1:0]  o_d,
    output logic [W-1:0]  o_x
);

    sia_pkg::t_ctl r_ctl;
    logic [W-1:0]  r_r, r_d, r_x;
    logic [W-1:0]  n_r, n_d, n_x;
    logic [W:0]    w_t, w_diff;
    logic          w_ge;

    assign w_t    = {i_r, i_x[W-1]};
    assign w_diff = w_t - {1'b0, i_d};
    assign w_ge   = (w_t >= {1'b0, i_d});

    always_comb begin
        unique case (i_ctl.kind)
            sia_pkg::K_MUL: begin
                n_r = i_x[0] ? (i_r + i_d) : i_r;
                n_d = i_d << 1;
                n_x = i_x >> 1;
            end
            sia_pkg::K_DIV, sia_pkg::K_MOD: begin
                n_r = w_ge ? w_diff[W-1:0] : w_t[W-1:0];
                n_d = i_d;
                n_x = {i_x[W-2:0], w_ge};
            end
            sia_pkg::K_PASS: begin
                n_r = i_r;
                n_d = i_d;
                n_x = i_x;
            end
            default: begin
                n_r = i_r;
                n_d = i_d;
                n_x = i_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_r;
            r_d <= n_d;
            r_x <= n_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_r   = r_r;
    assign o_d   = r_d;
    assign o_x   = r_x;

endmodule

// ----- hdl/signed_integer_alu64.sv -----
// Signed integer ALU, DATA_WIDTH-bit two's complement, wrapping arithmetic.
// One transaction in, one out: tuser on the input is the opcode, tdata the two
// operands; tuser on the output is the status (ok, divide by zero, shift out of
// range), tdata the sign-extended result. It accepts one transaction every cycle
// unless the output side stalls. Each transaction passes the input register, a
// chain of DATA_WIDTH cells (one multiplier bit or one quotient bit per cell) and
// the output register. Every operation runs through the whole chain so results
// stay in order. Ready follows the output side: the pipeline moves while the
// output register is empty or being taken.
`include "signed_integer_alu64_macros.svh"
module signed_integer_alu64 #(
    parameter int DATA_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [4:0]   i_s_axis_tuser,   // [4:0] action
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,   // [63:0] value
    output logic [1:0]   o_m_axis_tuser    // [1:0] status
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    logic w_en;

    // input decode
    logic [W-1:0]    w_a, w_b, w_ma, w_mb, w_sh;
    logic [CW-1:0]   w_cnt;
    logic            w_bad_sh, w_b_zero;
    sia_pkg::t_ctl   n_ctl0;
    logic [W-1:0]    n_r0, n_d0, n_x0;

    sia_pkg::t_ctl   r_ctl0;
    logic [W-1:0]    r_r0, r_d0, r_x0;

    // cell chain taps
    sia_pkg::t_ctl   w_ctl [0:W];
    logic [W-1:0]    w_r   [0:W];
    logic [W-1:0]    w_d   [0:W];
    logic [W-1:0]    w_x   [0:W];

    // output stage
    logic [W-1:0]    n_val;
    logic            r_ovld;
    logic [63:0]     r_odata;
    logic [1:0]      r_ouser;

    assign w_en            = !r_ovld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_a      = i_s_axis_tdata[W-1:0];
    assign w_b      = i_s_axis_tdata[64+W-1:64];
    assign w_ma     = w_a[W-1] ? (~w_a + 1'b1) : w_a;
    assign w_mb     = w_b[W-1] ? (~w_b + 1'b1) : w_b;
    assign w_b_zero = (w_b == '0);
    // negative counts are out of range too
    assign w_bad_sh = w_b[W-1] || (w_b > W'(W-1));
    assign w_cnt    = w_b[CW-1:0];

    always_comb begin
        n_ctl0.vld  = i_s_axis_tvalid;
        n_ctl0.kind = sia_pkg::K_PASS;
        n_ctl0.neg  = 1'b0;
        n_ctl0.st   = sia_pkg::ST_OK;
        n_r0        = '0;
        n_d0        = '0;
        n_x0        = '0;
        w_sh        = '0;
        unique case (sia_pkg::t_op'(i_s_axis_tuser))
            sia_pkg::OP_MUL: begin
                n_ctl0.kind = sia_pkg::K_MUL;
                n_d0        = w_a;
                n_x0        = w_b;
            end
            sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
                if (w_b_zero) begin
                    n_ctl0.st = sia_pkg::ST_DIV0;
                end else begin
                    if (sia_pkg::t_op'(i_s_axis_tuser) == sia_pkg::OP_DIV) begin
                        n_ctl0.kind = sia_pkg::K_DIV;
                        n_ctl0.neg  = w_a[W-1] ^ w_b[W-1];
                    end else begin
                        n_ctl0.kind = sia_pkg::K_MOD;
                        n_ctl0.neg  = w_a[W-1];
                    end
                    n_d0 = w_mb;
                    n_x0 = w_ma;
                end
            end
            sia_pkg::OP_ADD:    n_r0 = w_a + w_b;
            sia_pkg::OP_SUB:    n_r0 = w_a - w_b;
            sia_pkg::OP_SHL, sia_pkg::OP_SAR, sia_pkg::OP_SHR: begin
                if (sia_pkg::t_op'(i_s_axis_tuser) == sia_pkg::OP_SHL) begin
                    w_sh = w_a << w_cnt;
                end else if (sia_pkg::t_op'(i_s_axis_tuser) == sia_pkg::OP_SAR) begin
                    w_sh = $unsigned($signed(w_a) >>> w_cnt);
                end else begin
                    w_sh = w_a >> w_cnt;
                end
                if (w_bad_sh) begin
                    n_ctl0.st = sia_pkg::ST_SHIFT;
                end else begin
                    n_r0 = w_sh;
                end
            end
            sia_pkg::OP_AND:    n_r0 = w_a & w_b;
            sia_pkg::OP_XOR:    n_r0 = w_a ^ w_b;
            sia_pkg::OP_OR:     n_r0 = w_a | w_b;
            sia_pkg::OP_LT:     n_r0 = W'($signed(w_a) < $signed(w_b));
            sia_pkg::OP_GT:     n_r0 = W'($signed(w_b) < $signed(w_a));
            sia_pkg::OP_LE:     n_r0 = W'(!($signed(w_b) < $signed(w_a)));
            sia_pkg::OP_GE:     n_r0 = W'(!($signed(w_a) < $signed(w_b)));
            sia_pkg::OP_EQ:     n_r0 = W'(w_a == w_b);
            sia_pkg::OP_NE:     n_r0 = W'(w_a != w_b);
            sia_pkg::OP_LAND:   n_r0 = W'((w_a != '0) && !w_b_zero);
            sia_pkg::OP_LOR:    n_r0 = W'((w_a != '0) || !w_b_zero);
            sia_pkg::OP_BITNOT: n_r0 = ~w_a;
            sia_pkg::OP_LNOT:   n_r0 = W'(w_a == '0);
            sia_pkg::OP_NEG:    n_r0 = ~w_a + 1'b1;
            sia_pkg::OP_POS:    n_r0 = w_a;
            default:            n_r0 = '0;   // unused opcodes give zero, ok
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_en) begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r0 <= n_r0;
            r_d0 <= n_d0;
            r_x0 <= n_x0;
        end
    end

    assign w_ctl[0] = r_ctl0;
    assign w_r[0]   = r_r0;
    assign w_d[0]   = r_d0;
    assign w_x[0]   = r_x0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        sia_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_r     (w_r[g]),
            .i_d     (w_d[g]),
            .i_x     (w_x[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_r     (w_r[g+1]),
            .o_d     (w_d[g+1]),
            .o_x     (w_x[g+1])
        );
    end

    // final sign fix-up and result select
    always_comb begin
        unique case (w_ctl[W].kind)
            sia_pkg::K_DIV:  n_val = w_ctl[W].neg ? (~w_x[W] + 1'b1) : w_x[W];
            sia_pkg::K_MOD:  n_val = w_ctl[W].neg ? (~w_r[W] + 1'b1) : w_r[W];
            sia_pkg::K_MUL:  n_val = w_r[W];
            sia_pkg::K_PASS: n_val = w_r[W];
            default:         n_val = w_r[W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_ctl[W].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= 64'($signed(n_val));
            r_ouser <= w_ctl[W].st;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `SIA_ASSERT(a_err_zero, (r_ovld && (r_ouser != sia_pkg::ST_OK)) |-> (r_odata == '0), "flagged result not zero")
    `SIA_ASSERT(a_status_code, r_ovld |-> (r_ouser != 2'd3), "undefined status code")
    `SIA_ASSERT(a_stall_hold, (r_ovld && !i_m_axis_tready) |=> (r_ovld && $stable(r_odata)), "stalled result lost")
    `SIA_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !r_ovld, "output valid after reset")

endmodule

// ----- bench/tb_signed_integer_alu64.sv -----
`timescale 1ns / 100ps

module tb_signed_integer_alu64;

    localparam int DATA_WIDTH = 64;
    localparam int LATENCY    = DATA_WIDTH + 2;
    localparam longint MAX_CYCLES = 400000;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // One ALU operation as offered on the slave side
    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] opa;
        logic [63:0] opb;
    } t_alu_op;

    // One ALU result as seen on the master side
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_alu_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;   // [63:0] operand_a, [127:64] operand_b
    logic [4:0]   i_s_axis_tuser;   // [4:0] action
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [63:0]  o_m_axis_tdata;   // [63:0] value
    logic [1:0]   o_m_axis_tuser;   // [1:0] status

    signed_integer_alu64 #(.DATA_WIDTH(DATA_WIDTH)) DUT (.*);

    t_alu_op  pending_ops[$];
    t_alu_res expected_results[$];
    int       send_idle_pct;   // percent of cycles the sender holds off
    int       recv_stall_pct;  // percent of cycles the receiver stalls
    int       errors;
    int       ops_sent;
    int       results_seen;
    int       ops_covered;
    longint   cycle_count;
    bit       hold_mask [32];  // opcodes exercised, for the summary

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Golden ALU: computes the result of one operation at 64 bits
    function automatic t_alu_res alu_compute(t_alu_op op);
        logic signed [63:0] a, b;
        logic [63:0]        ma, mb, q;
        t_alu_res           res;
        a = op.opa;
        b = op.opb;
        res.value  = '0;
        res.status = sia_pkg::ST_OK;
        case (op.action)
            sia_pkg::OP_MUL: res.value = a * b;
            sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
                if (b == 0) begin
                    res.status = sia_pkg::ST_DIV0;
                end else begin
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    if (op.action == sia_pkg::OP_DIV) begin
                        q = ma / mb;
                        res.value = (a[63] != b[63]) ? -q : q;
                    end else begin
                        q = ma % mb;
                        res.value = a[63] ? -q : q;
                    end
                end
            end
            sia_pkg::OP_ADD: res.value = a + b;
            sia_pkg::OP_SUB: res.value = a - b;
            sia_pkg::OP_SHL, sia_pkg::OP_SAR, sia_pkg::OP_SHR: begin
                // count is unsigned view of b: negative counts are out of range
                if ($unsigned(b) >= DATA_WIDTH) begin
                    res.status = sia_pkg::ST_SHIFT;
                end else if (op.action == sia_pkg::OP_SHL) begin
                    res.value = a << b[5:0];
                end else if (op.action == sia_pkg::OP_SAR) begin
                    res.value = a >>> b[5:0];
                end else begin
                    res.value = $unsigned(a) >> b[5:0];
                end
            end
            sia_pkg::OP_AND:    res.value = a & b;
            sia_pkg::OP_XOR:    res.value = a ^ b;
            sia_pkg::OP_OR:     res.value = a | b;
            sia_pkg::OP_LT:     res.value = {63'd0, a < b};
            sia_pkg::OP_GT:     res.value = {63'd0, a > b};
            sia_pkg::OP_LE:     res.value = {63'd0, a <= b};
            sia_pkg::OP_GE:     res.value = {63'd0, a >= b};
            sia_pkg::OP_EQ:     res.value = {63'd0, a == b};
            sia_pkg::OP_NE:     res.value = {63'd0, a != b};
            sia_pkg::OP_LAND:   res.value = {63'd0, (a != 0) && (b != 0)};
            sia_pkg::OP_LOR:    res.value = {63'd0, (a != 0) || (b != 0)};
            sia_pkg::OP_BITNOT: res.value = ~a;
            sia_pkg::OP_LNOT:   res.value = {63'd0, a == 0};
            sia_pkg::OP_NEG:    res.value = -a;
            sia_pkg::OP_POS:    res.value = a;
            default:            res.value = '0;   // unused opcodes give zero, status ok
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand with bias toward edge values and small magnitudes
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN64;
            1: return MAX64;
            2: return 64'd0;
            3: return '1;
            4: return 64'd1;
            5: return {{60{1'b0}}, 4'($urandom())} - 64'd8;
            6: return {{48{1'b0}}, 16'($urandom())} ^ {64{$urandom_range(0, 1) == 1}};
            default: return rand64();
        endcase
    endfunction

    task automatic queue_op(logic [4:0] action, logic [63:0] opa, logic [63:0] opb);
        t_alu_op op;
        op.action = action;
        op.opa    = opa;
        op.opb    = opb;
        pending_ops = {pending_ops, op};
    endtask

    task automatic queue_random_ops(int count);
        logic [4:0]  act;
        logic [63:0] b;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                : 5'($urandom_range(sia_pkg::OP_MUL, sia_pkg::OP_POS));
            b = pick_operand();
            // shift counts mostly in range so the shifter itself gets exercised
            if ((act inside {sia_pkg::OP_SHL, sia_pkg::OP_SAR, sia_pkg::OP_SHR})
                && $urandom_range(0, 3) != 0)
                b = 64'($urandom_range(0, 63));
            queue_op(act, pick_operand(), b);
        end
    endtask

    // Driver: offers pending operations, idling at random per phase setting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results = {expected_results, alu_compute(
                    t_alu_op'{i_s_axis_tuser, i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]})};
                hold_mask[i_s_axis_tuser] = 1'b1;
                ops_sent++;
            end
            if ((!i_s_axis_tvalid || o_s_axis_tready) ) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_alu_op op;
                    op = pending_ops.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= op.action;
                    i_s_axis_tdata  <= {op.opb, op.opa};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%h status=%0d",
                             $realtime, o_m_axis_tdata, o_m_axis_tuser);
                    errors++;
                end else begin
                    t_alu_res exp_res;
                    exp_res = expected_results.pop_front();
                    if (o_m_axis_tdata !== exp_res.value) begin
                        $display("%0t: value mismatch expected=%h actual=%h",
                                 $realtime, exp_res.value, o_m_axis_tdata);
                        errors++;
                    end
                    if (o_m_axis_tuser !== exp_res.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $realtime, exp_res.status, o_m_axis_tuser);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_ops(count);
        while (pending_ops.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        errors          = 0;
        ops_sent        = 0;
        results_seen    = 0;
        ops_covered     = 0;
        cycle_count     = 0;

        // Directed: every opcode plus the corner cases
        queue_op(sia_pkg::OP_MUL, MAX64, MAX64);
        queue_op(sia_pkg::OP_MUL, MIN64, '1);
        queue_op(sia_pkg::OP_DIV, 64'd7, 64'd0);     // divide by zero
        queue_op(sia_pkg::OP_MOD, MIN64, 64'd0);     // modulo by zero
        queue_op(sia_pkg::OP_DIV, MIN64, '1);        // minimum over minus one wraps
        queue_op(sia_pkg::OP_MOD, MIN64, '1);
        queue_op(sia_pkg::OP_DIV, -64'sd7, 64'd2);
        queue_op(sia_pkg::OP_MOD, -64'sd7, 64'd2);
        queue_op(sia_pkg::OP_ADD, MAX64, 64'd1);
        queue_op(sia_pkg::OP_SUB, MIN64, 64'd1);
        queue_op(sia_pkg::OP_SHL, '1, 64'd63);
        queue_op(sia_pkg::OP_SHL, 64'd1, 64'd64);    // count out of range
        queue_op(sia_pkg::OP_SAR, MIN64, 64'd63);
        queue_op(sia_pkg::OP_SHR, MIN64, 64'd63);
        queue_op(sia_pkg::OP_SHR, '1, '1);           // negative count
        queue_op(sia_pkg::OP_AND, MAX64, MIN64);
        queue_op(sia_pkg::OP_XOR, '1, MAX64);
        queue_op(sia_pkg::OP_OR,  MIN64, 64'd1);
        queue_op(sia_pkg::OP_LT,  MIN64, MAX64);
        queue_op(sia_pkg::OP_GT,  MIN64, MAX64);
        queue_op(sia_pkg::OP_LE,  MAX64, MAX64);
        queue_op(sia_pkg::OP_GE,  '1, 64'd0);
        queue_op(sia_pkg::OP_EQ,  MIN64, MIN64);
        queue_op(sia_pkg::OP_NE,  64'd0, 64'd0);
        queue_op(sia_pkg::OP_LAND, MIN64, 64'd0);
        queue_op(sia_pkg::OP_LOR,  64'd0, 64'd0);
        queue_op(sia_pkg::OP_BITNOT, MIN64, 64'd5);
        queue_op(sia_pkg::OP_LNOT, 64'd0, '1);
        queue_op(sia_pkg::OP_NEG, MIN64, 64'd0);
        queue_op(sia_pkg::OP_POS, MAX64, '1);
        queue_op(5'd31, '1, '1);                     // unused opcode

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(0, 0, 140);
        run_phase(76, 0, 100);
        run_phase(0, 76, 100);
        run_phase(19, 19, 110);

        // last offer may still be waiting for acceptance
        while (i_s_axis_tvalid || expected_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (results_seen != ops_sent) begin
            $display("%0t: result count mismatch expected=%0d actual=%0d",
                     $realtime, ops_sent, results_seen);
            errors++;
        end

        foreach (hold_mask[k]) begin
            if (hold_mask[k]) ops_covered++;
        end

        $display("Sent %0d ALU operations, checked %0d results across four idle/stall phases.",
                 ops_sent, results_seen);
        $display("%0d distinct opcodes exercised, edge operands and bad counts included.",
                 ops_covered);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
